@@ src/skt_pkg.sv @@
// skt_pkg: request/result payload types, cell command and flag types,
// operation and status codes for the sorted key table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    typedef logic signed [31:0] skt_key_t;
    typedef logic signed [31:0] skt_bal_t;
    typedef logic        [1:0]  skt_op_t;
    typedef logic        [1:0]  skt_status_t;

    localparam skt_op_t OP_LOOKUP = 2'd0;
    localparam skt_op_t OP_INSERT = 2'd1;
    localparam skt_op_t OP_DELETE = 2'd2;

    localparam skt_status_t ST_DONE      = 2'd0;
    localparam skt_status_t ST_MISSING   = 2'd1;
    localparam skt_status_t ST_DUPLICATE = 2'd2;
    localparam skt_status_t ST_FULL      = 2'd3;

    typedef struct packed {
        skt_op_t  operation;
        skt_key_t key;
        skt_bal_t balance_in;
    } skt_req_t;

    typedef struct packed {
        skt_status_t status;
        skt_bal_t    balance_out;
        logic [5:0]  position;
        logic [6:0]  entry_count;
    } skt_rsp_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic     compare;   // latch lt/eq flags against key
        logic     insert;    // open a slot at the boundary, load key/balance
        logic     remove;    // close the slot at the boundary
        skt_key_t key;
        skt_bal_t balance;
    } skt_cmd_t;

    // per-cell compare flags
    typedef struct packed {
        logic live;  // cell index below entry count
        logic lt;    // live and stored key below request key
        logic eq;    // stored key equals request key
    } skt_flags_t;

endpackage

`default_nettype wire

@@ src/skt_cell.sv @@
// skt_cell: one table slot. Holds a key and balance, latches compare flags,
// shifts from either neighbor on insert/delete. Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  wire logic             aclk,
    input  wire skt_cmd_t         cmd,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             prev_lt,
    input  wire skt_key_t         prev_key,
    input  wire skt_bal_t         prev_bal,
    input  wire skt_key_t         next_key,
    input  wire skt_bal_t         next_bal,
    output skt_key_t              key_o,
    output skt_bal_t              bal_o,
    output skt_flags_t            flags_o,
    output logic                  sel_o
);

    skt_key_t   key_reg, key_next;
    skt_bal_t   bal_reg, bal_next;
    skt_flags_t flags_reg, flags_next;
    logic       live;

    // boundary cell: first one whose key is not below the request key
    assign sel_o = !flags_reg.lt && prev_lt;
    assign live  = CNT_W'(cell_index) < count;

    always_comb begin
        flags_next = flags_reg;
        if (cmd.compare) begin
            flags_next.live = live;
            flags_next.lt   = live && (key_reg < cmd.key);
            flags_next.eq   = (key_reg == cmd.key);
        end
    end

    always_comb begin
        key_next = key_reg;
        bal_next = bal_reg;
        if (cmd.insert) begin
            if (sel_o) begin
                key_next = cmd.key;
                bal_next = cmd.balance;
            end else if (!prev_lt) begin
                key_next = prev_key;
                bal_next = prev_bal;
            end
        end else if (cmd.remove) begin
            if (!flags_reg.lt) begin
                key_next = next_key;
                bal_next = next_bal;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        bal_reg   <= bal_next;
        flags_reg <= flags_next;
    end

    assign key_o   = key_reg;
    assign bal_o   = bal_reg;
    assign flags_o = flags_reg;

endmodule

`default_nettype wire

@@ src/skt_reduce.sv @@
// skt_reduce: folds the one-hot boundary select of the cell row into a hit
// flag, a slot index and the selected balance. Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_reduce
    import skt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic       sel   [DEPTH],
    input  wire skt_flags_t flags [DEPTH],
    input  wire skt_bal_t   bals  [DEPTH],
    output logic            hit,
    output logic [IDX_W-1:0] idx,
    output skt_bal_t        bal
);

    // at most one select is high, so a plain OR tree picks it
    always_comb begin
        hit = 1'b0;
        idx = '0;
        bal = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel[i]) begin
                hit = hit | (flags[i].eq & flags[i].live);
                idx = idx | IDX_W'(i);
                bal = bal | bals[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/sorted_key_table.sv @@
// sorted_key_table: top level. Request/response handshakes, entry count,
// cell row and select fold. Depends on skt_pkg, skt_cell, skt_reduce.
//
// A table of up to DEPTH entries kept in ascending signed key order, one
// slot per cell in a row. When a request is accepted, every cell compares
// its stored key against the request key and latches its flags; in the
// update state the boundary cell is located from neighbor flags, the row
// shifts one place up (insert) or down (delete), and the response is
// registered. s_ready is low in the update state, so a new request is not
// accepted before the previous one commits; if the previous response is
// still waiting on m_ready, the commit holds until it is taken. The
// response register lets a new request be accepted while a result waits.
// Status: done, key not found, duplicate key (position of the existing
// entry), table full. Operation code three behaves as a miss. No clearing
// pass after reset: only slots below the entry count are ever consulted.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire skt_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output skt_rsp_t      m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic             state_reg, state_next;
    skt_req_t         req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    skt_rsp_t         rsp_reg, rsp_next;

    logic accept, commit;
    skt_cmd_t cmd;

    // cell row
    skt_key_t   cell_key   [DEPTH];
    skt_bal_t   cell_bal   [DEPTH];
    skt_flags_t cell_flags [DEPTH];
    logic       cell_sel   [DEPTH];

    logic             hit;
    logic [IDX_W-1:0] idx;
    skt_bal_t         sel_bal;
    logic             full;

    logic [IDX_W+5:0] pos_ext;
    logic [CNT_W+6:0] cnt_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign full    = (count_reg == CNT_W'(DEPTH));

    // position field is the low bits of the slot index
    assign pos_ext = {6'd0, idx};

    always_comb begin
        cmd.compare = accept;
        cmd.insert  = commit && (req_reg.operation == OP_INSERT) && !hit && !full;
        cmd.remove  = commit && (req_reg.operation == OP_DELETE) && hit;
        cmd.key     = (state_reg == ST_UPDATE) ? req_reg.key : s_data.key;
        cmd.balance = req_reg.balance_in;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic     prev_lt;
            skt_key_t prev_key, next_key;
            skt_bal_t prev_bal, next_bal;

            if (g == 0) begin : g_first
                assign prev_lt  = 1'b1;
                assign prev_key = '0;
                assign prev_bal = '0;
            end else begin : g_mid
                assign prev_lt  = cell_flags[g-1].lt;
                assign prev_key = cell_key[g-1];
                assign prev_bal = cell_bal[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign next_key = '0;
                assign next_bal = '0;
            end else begin : g_inner
                assign next_key = cell_key[g+1];
                assign next_bal = cell_bal[g+1];
            end

            skt_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .cell_index (IDX_W'(g)),
                .count      (count_reg),
                .prev_lt    (prev_lt),
                .prev_key   (prev_key),
                .prev_bal   (prev_bal),
                .next_key   (next_key),
                .next_bal   (next_bal),
                .key_o      (cell_key[g]),
                .bal_o      (cell_bal[g]),
                .flags_o    (cell_flags[g]),
                .sel_o      (cell_sel[g])
            );
        end
    endgenerate

    skt_reduce #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_reduce (
        .sel   (cell_sel),
        .flags (cell_flags),
        .bals  (cell_bal),
        .hit   (hit),
        .idx   (idx),
        .bal   (sel_bal)
    );

    // commit decision
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            req_next   = s_data;
            state_next = ST_UPDATE;
        end

        if (commit) begin
            state_next           = ST_IDLE;
            m_valid_next         = 1'b1;
            rsp_next.status      = ST_MISSING;
            rsp_next.balance_out = '0;
            rsp_next.position    = '0;
            unique case (req_reg.operation)
                OP_LOOKUP: begin
                    if (hit) begin
                        rsp_next.status      = ST_DONE;
                        rsp_next.balance_out = sel_bal;
                        rsp_next.position    = pos_ext[5:0];
                    end
                end
                OP_INSERT: begin
                    if (hit) begin
                        rsp_next.status   = ST_DUPLICATE;
                        rsp_next.position = pos_ext[5:0];
                    end else if (full) begin
                        rsp_next.status = ST_FULL;
                    end else begin
                        rsp_next.status   = ST_DONE;
                        rsp_next.position = pos_ext[5:0];
                        count_next        = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE: begin
                    if (hit) begin
                        rsp_next.status   = ST_DONE;
                        rsp_next.position = pos_ext[5:0];
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry_count field is the low bits of the count after the operation
    assign cnt_ext = {7'd0, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        if (commit) begin
            rsp_reg <= {rsp_next.status, rsp_next.balance_out, rsp_next.position,
                        cnt_ext[6:0]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

`default_nettype wire

@@ src/skt_checker.sv @@
// skt_checker: port-level assertions for sorted_key_table, bound to the top.
// Depends on skt_pkg and sorted_key_table.
`timescale 1ns / 1ps
`default_nettype none

module skt_checker
    import skt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire skt_req_t s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire skt_rsp_t m_data
);

    // a pending response holds until taken
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    // a request is never accepted in the cycle right after another
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted during update cycle");

    // misses carry no position and no balance
    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_MISSING) |->
            (m_data.position == 6'd0) && (m_data.balance_out == '0))
        else $error("miss response with nonzero fields");

    // a full refusal reports a full table
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |->
            (m_data.entry_count == 7'(DEPTH)) && (m_data.balance_out == '0))
        else $error("full status with wrong count");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (DEPTH > 64) || (m_data.entry_count <= 7'(DEPTH)))
        else $error("entry count above table size");

endmodule

bind sorted_key_table skt_checker #(
    .DEPTH (DEPTH)
) u_skt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ bench/sorted_key_table_tb.sv @@
// sorted_key_table_tb: self-checking bench for the sorted key table. It runs a directed table,
// then fill/churn/drain rounds of random requests against a behavioral table copy.
// Depends on skt_pkg and sorted_key_table.
`timescale 1ns / 1ps

module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    // No-accept stretch of a correct run: the HOLD_CYCLES hold-off, plus the longest stall
    // and the longest gap, plus the update of one request. IDLE_LIMIT leaves plenty of slack.
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int POOL_SIZE     = 96;
    localparam int CHURN_POOL    = 48;
    localparam int DIRECTED_ROWS = 23;

    // operation code three is unused by the block and must behave as a miss
    localparam skt_op_t OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {SINK_RANDOM, SINK_HOLD, SINK_STEADY} sink_mode_t;

    // one directed request; typed rows carry a hand-written expected result
    typedef struct packed {
        skt_req_t req;
        logic     typed;
        skt_rsp_t rsp;
    } dir_row_t;

    typedef struct packed {
        logic     typed;
        skt_rsp_t rsp;
    } typed_rsp_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    skt_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    skt_rsp_t m_data;

    sorted_key_table #(
        .DEPTH(TABLE_DEPTH)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 2 ns clock, first rising edge at 1 ns
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------------
    // Behavioral copy of the table: keys ascending by signed value.
    // ---------------------------------------------------------------------
    skt_key_t tbl_keys [TABLE_DEPTH];
    skt_bal_t tbl_bals [TABLE_DEPTH];
    int       tbl_count;

    skt_rsp_t   pending_rsp [$];  // results still owed by the block, oldest first
    typed_rsp_t typed_q [$];      // per offered request: hand-written result or none
    int         mismatch_count;
    int         result_index;
    int         idle_cycles;
    sink_mode_t sink_mode;
    int         calm_left;
    skt_key_t   key_pool [POOL_SIZE];
    dir_row_t   directed_rows [DIRECTED_ROWS];

    // Apply one request to the table copy and return the result it must produce.
    function automatic skt_rsp_t table_apply(skt_req_t req);
        skt_rsp_t rsp;
        int       slot;
        int       i;
        bit       hit;
        rsp        = '0;
        rsp.status = ST_MISSING;
        // lower bound: first slot whose key is not below the request key
        slot = 0;
        while (slot < tbl_count && $signed(tbl_keys[slot]) < $signed(req.key))
            slot++;
        hit = (slot < tbl_count) && (tbl_keys[slot] == req.key);
        case (req.operation)
            OP_LOOKUP: begin
                if (hit) begin
                    rsp.status      = ST_DONE;
                    rsp.balance_out = tbl_bals[slot];
                    rsp.position    = 6'(slot);
                end
            end
            OP_INSERT: begin
                // duplicate wins over full
                if (hit) begin
                    rsp.status   = ST_DUPLICATE;
                    rsp.position = 6'(slot);
                end else if (tbl_count >= TABLE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = tbl_count; i > slot; i--) begin
                        tbl_keys[i] = tbl_keys[i - 1];
                        tbl_bals[i] = tbl_bals[i - 1];
                    end
                    tbl_keys[slot] = req.key;
                    tbl_bals[slot] = req.balance_in;
                    tbl_count++;
                    rsp.status   = ST_DONE;
                    rsp.position = 6'(slot);
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    for (i = slot; i + 1 < tbl_count; i++) begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_bals[i] = tbl_bals[i + 1];
                    end
                    tbl_count--;
                    rsp.status   = ST_DONE;
                    rsp.position = 6'(slot);
                end
            end
            default: ;  // unused code: table untouched, reported as a miss
        endcase
        rsp.entry_count = 7'(tbl_count);
        return rsp;
    endfunction

    function automatic dir_row_t directed_row(skt_op_t op, skt_key_t key, skt_bal_t bal,
                                              logic typed, skt_status_t status,
                                              skt_bal_t bout, logic [5:0] pos,
                                              logic [6:0] cnt);
        dir_row_t row;
        row.req.operation   = op;
        row.req.key         = key;
        row.req.balance_in  = bal;
        row.typed           = typed;
        row.rsp.status      = status;
        row.rsp.balance_out = bout;
        row.rsp.position    = pos;
        row.rsp.entry_count = cnt;
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t result %0d: %s", $realtime, result_index, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------
    // Monitor: results are checked before a request accepted on the same edge is
    // predicted. The table copy advances on every accepted request.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        skt_rsp_t   want;
        skt_rsp_t   predicted;
        typed_rsp_t row;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing pending", m_data));
                end else begin
                    want = pending_rsp.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_data.status, want.status));
                    if (m_data.balance_out !== want.balance_out)
                        report_mismatch($sformatf("balance_out %h, want %h",
                                                  m_data.balance_out, want.balance_out));
                    if (m_data.position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  m_data.position, want.position));
                    if (m_data.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  m_data.entry_count, want.entry_count));
                end
                result_index++;
            end
            if (s_valid && s_ready) begin
                predicted = table_apply(s_data);
                if (typed_q.size() != 0) begin
                    row = typed_q.pop_front();
                    pending_rsp.push_back(row.typed ? row.rsp : predicted);
                end else begin
                    pending_rsp.push_back(predicted);
                end
            end
        end
    end

    // Watchdog: ends the run once nothing has moved on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result side: random ready/stall bursts, one long hold-off on request,
    // steady ready in the closing part. m_ready changes on falling edges only.
    // ---------------------------------------------------------------------
    initial begin
        int len;
        int hold_left;
        bit stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1)
            @(negedge aclk);
        forever begin
            case (sink_mode)
                SINK_HOLD: begin
                    // long back-pressure: the block fills up and drops s_ready
                    @(negedge aclk);
                    m_ready   <= 1'b0;
                    hold_left  = HOLD_CYCLES - 1;
                    while (hold_left > 0) begin
                        @(negedge aclk);
                        hold_left--;
                    end
                    sink_mode = SINK_RANDOM;
                end
                SINK_STEADY: begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
                default: begin
                    stall = ($urandom_range(2) == 0);
                    len   = $urandom_range(1, 14);
                    if ($urandom_range(29) == 0) begin
                        stall = 1'b0;
                        len   = 60;  // stretch of uninterrupted ready
                    end
                    @(negedge aclk);
                    m_ready <= !stall;
                    // cut the burst short once the closing part begins
                    repeat (len - 1) begin
                        @(negedge aclk);
                        if (sink_mode == SINK_STEADY) begin
                            m_ready <= 1'b1;
                            break;
                        end
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------

    // Random gap ahead of a request when idle is set, with occasional stretches of no gaps.
    task automatic pace_sender(bit idle);
        int gap;
        if (idle) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(39) == 0) begin
                calm_left = 25;
            end else if ($urandom_range(2) == 0) begin
                gap = $urandom_range(1, 14);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Offer one request and hold it until accepted.
    task automatic send_request(skt_req_t req, logic typed, skt_rsp_t rsp);
        typed_rsp_t entry;
        entry.typed = typed;
        entry.rsp   = rsp;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        typed_q.push_back(entry);
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge aclk);
    endtask

    task automatic refill_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        // keep the extremes and the values around zero in the hot part of the pool
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
    endtask

    // Random requests drawn from the key pool; a few are noise (unused code, fresh key).
    task automatic run_phase(int items, int ins_pct, int del_pct, int pool_n, bit idle);
        skt_req_t req;
        int       r;
        int       n;
        for (n = 0; n < items; n++) begin
            r              = $urandom_range(99);
            req.key        = key_pool[$urandom_range(pool_n - 1)];
            req.balance_in = $urandom;
            if (r < ins_pct)
                req.operation = OP_INSERT;
            else if (r < ins_pct + del_pct)
                req.operation = OP_DELETE;
            else if (r < 97)
                req.operation = OP_LOOKUP;
            else
                req.operation = OP_UNUSED;
            if ($urandom_range(24) == 0)
                req.key = $urandom;
            pace_sender(idle);
            send_request(req, 1'b0, '0);
        end
    endtask

    initial begin
        int n;
        int round;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        sink_mode      = SINK_RANDOM;
        tbl_count      = 0;
        mismatch_count = 0;
        result_index   = 0;
        idle_cycles    = 0;
        calm_left      = 0;

        // directed: empty table, extremes of key and balance, done/missing/duplicate status
        directed_rows[0]  = directed_row(OP_LOOKUP, 32'sd5, '0, 1'b1, ST_MISSING, '0, 6'd0, 7'd0);
        directed_rows[1]  = directed_row(OP_DELETE, 32'sd5, '0, 1'b1, ST_MISSING, '0, 6'd0, 7'd0);
        directed_rows[2]  = directed_row(OP_UNUSED, 32'sd0, 32'hffff_ffff, 1'b1, ST_MISSING,
                                         '0, 6'd0, 7'd0);
        directed_rows[3]  = directed_row(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, ST_DONE,
                                         '0, 6'd0, 7'd1);
        directed_rows[4]  = directed_row(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, ST_DONE,
                                         '0, 6'd1, 7'd2);
        directed_rows[5]  = directed_row(OP_INSERT, 32'h0000_0000, 32'hffff_ffff, 1'b1, ST_DONE,
                                         '0, 6'd1, 7'd3);
        // -1 sorts below 0 under signed order
        directed_rows[6]  = directed_row(OP_INSERT, 32'hffff_ffff, 32'h0000_0100, 1'b1, ST_DONE,
                                         '0, 6'd1, 7'd4);
        directed_rows[7]  = directed_row(OP_INSERT, 32'h8000_0000, 32'h0000_0001, 1'b1,
                                         ST_DUPLICATE, '0, 6'd0, 7'd4);
        directed_rows[8]  = directed_row(OP_INSERT, 32'h7fff_ffff, 32'h0000_0001, 1'b1,
                                         ST_DUPLICATE, '0, 6'd3, 7'd4);
        directed_rows[9]  = directed_row(OP_LOOKUP, 32'h8000_0000, '0, 1'b1, ST_DONE,
                                         32'h7fff_ffff, 6'd0, 7'd4);
        directed_rows[10] = directed_row(OP_LOOKUP, 32'h7fff_ffff, '0, 1'b1, ST_DONE,
                                         32'h8000_0000, 6'd3, 7'd4);
        directed_rows[11] = directed_row(OP_LOOKUP, 32'sd1, '0, 1'b1, ST_MISSING, '0, 6'd0, 7'd4);
        // unused code on a key that is present still misses
        directed_rows[12] = directed_row(OP_UNUSED, 32'sd0, '0, 1'b1, ST_MISSING, '0, 6'd0, 7'd4);
        directed_rows[13] = directed_row(OP_DELETE, 32'hffff_ffff, '0, 1'b1, ST_DONE,
                                         '0, 6'd1, 7'd3);
        directed_rows[14] = directed_row(OP_DELETE, 32'hffff_ffff, '0, 1'b1, ST_MISSING,
                                         '0, 6'd0, 7'd3);
        directed_rows[15] = directed_row(OP_LOOKUP, 32'sd0, '0, 1'b1, ST_DONE,
                                         32'hffff_ffff, 6'd1, 7'd3);
        directed_rows[16] = directed_row(OP_INSERT, 32'sd1, 32'h1234_5678, 1'b0,
                                         ST_DONE, '0, '0, '0);
        directed_rows[17] = directed_row(OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0,
                                         ST_DONE, '0, '0, '0);
        directed_rows[18] = directed_row(OP_INSERT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0,
                                         ST_DONE, '0, '0, '0);
        directed_rows[19] = directed_row(OP_DELETE, 32'h8000_0000, '0, 1'b0, ST_DONE, '0, '0, '0);
        directed_rows[20] = directed_row(OP_LOOKUP, 32'haaaa_aaaa, '0, 1'b0, ST_DONE, '0, '0, '0);
        directed_rows[21] = directed_row(OP_DELETE, 32'h7fff_ffff, '0, 1'b0, ST_DONE, '0, '0, '0);
        directed_rows[22] = directed_row(OP_LOOKUP, 32'sd1, '0, 1'b0, ST_DONE, '0, '0, '0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            pace_sender(1'b1);
            send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rsp);
        end

        // two rounds of churn, fill past full, then a delete-heavy drain
        for (round = 0; round < 2; round++) begin
            refill_pool();
            if (round == 0)
                sink_mode = SINK_HOLD;  // sender keeps offering through the hold-off
            run_phase(300, 35, 30, CHURN_POOL, 1'b1);
            run_phase(200, 80, 5, POOL_SIZE, 1'b1);
            if (round == 0) begin
                // sender pause with the table full: let every result come home first
                @(negedge aclk);
                s_valid <= 1'b0;
                wait_drained();
            end
            run_phase(200, 5, 80, POOL_SIZE, 1'b1);
        end

        // closing part: no idling on either side
        sink_mode = SINK_STEADY;
        refill_pool();
        run_phase(150, 80, 5, POOL_SIZE, 1'b0);
        run_phase(150, 35, 30, CHURN_POOL, 1'b0);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
